FILE: rtl/mmt_pkg.sv
package mmt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int MAX_TASKS   = 16;
	localparam int IDX_W       = 4;
	localparam int CNT_W       = 5;
	localparam int TASK_W      = 4;
	localparam int PAY_W       = 32;
	localparam int SEQ_W       = 4;

	typedef enum logic [2:0] {
		REQ_SEND   = 3'd0,
		REQ_COUNT  = 3'd1,
		REQ_FIRST  = 3'd2,
		REQ_LAST   = 3'd3,
		REQ_LIST   = 3'd4,
		REQ_REMOVE = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_BAD_TASK = 3'd1,
		STS_NONE     = 3'd2,
		STS_FULL     = 3'd3,
		STS_BAD_SLOT = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RM_READ,
		S_RM_CAP,
		S_SCAN,
		S_SEND_WR,
		S_RESULT,
		S_LIST_RD,
		S_LIST_CHK,
		S_SH_RD,
		S_SH_WR
	} state_t;

	typedef struct packed {
		logic [TASK_W-1:0] dest;
		logic [TASK_W-1:0] src;
		logic [PAY_W-1:0]  pay;
		logic [SEQ_W-1:0]  seq;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_run;
		logic rd_slot;
		logic rd_list;
		logic rd_shift;
		logic rm_cap;
		logic wr_send;
		logic wr_shift;
		logic list_emit;
		logic list_skip;
		logic fill_dec;
		logic res_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		req_t req;
		logic bad_task;
		logic slot_bad;
		logic full;
		logic cnt_zero;
		logic scan_done;
		logic shift_more;
		logic list_hit;
		logic list_last;
		logic out_free;
	} stat_t;

endpackage

FILE: rtl/message_mailbox_table.sv
// Mailbox table of 16 entries kept in arrival order.
// Requests enter on in_valid/in_ready with req_type, dest_task, src_task,
// payload and slot; results leave on out_valid/out_ready. Every request gives
// one result with last set, except list with matches, giving one per matching
// entry (last on the final one), and the unused request codes, giving none.
// tasks_in_use is written through cfg_we/cfg_wdata; the user must do so only
// while the table is idle, as the block does not enforce it. Work per request:
//   bad task, bad slot: result built straight after decode, with no scan.
//   count, read first/last: the count scan, send adds a write; the count scan
//     reads one entry per cycle from the single read port of the entry table.
//   list: the count scan, then a read and check per entry up to the last hit.
//   remove: slot read and the count scan, then a read and a write for each
//     entry shifted down behind the slot.
// One request is in flight at a time; a new one is taken as soon as the last
// result sits in the output register, even while that result is stalled.
// A stalled receiver holds the result and pauses a list mid-way.
// Reset empties the table (fill level zero, no clearing pass) and sets
// tasks_in_use to 1.
module message_mailbox_table
	import mmt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        req_type,
	input  logic [TASK_W-1:0] dest_task,
	input  logic [TASK_W-1:0] src_task,
	input  logic [PAY_W-1:0]  payload,
	input  logic [IDX_W-1:0]  slot,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [CNT_W-1:0]  match_count,
	output logic [IDX_W-1:0]  found_slot,
	output logic [TASK_W-1:0] found_source,
	output logic [PAY_W-1:0]  found_payload,
	output logic [SEQ_W-1:0]  found_sequence,
	output logic              last
);

	cmd_t  cmd;
	stat_t stat;

	mmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mmt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.req_type       (req_type),
		.dest_task      (dest_task),
		.src_task       (src_task),
		.payload        (payload),
		.slot           (slot),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.match_count    (match_count),
		.found_slot     (found_slot),
		.found_source   (found_source),
		.found_payload  (found_payload),
		.found_sequence (found_sequence),
		.last           (last)
	);

endmodule

FILE: rtl/mmt_ctrl.sv
module mmt_ctrl
	import mmt_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (stat.req)
					REQ_REMOVE: state_d = stat.slot_bad ? S_RESULT : S_RM_READ;
					REQ_SEND, REQ_COUNT, REQ_FIRST, REQ_LAST, REQ_LIST: begin
						state_d = stat.bad_task ? S_RESULT : S_SCAN;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_RM_READ: state_d = S_RM_CAP;
			S_RM_CAP:  state_d = S_SCAN;
			S_SCAN: begin
				if (stat.scan_done) begin
					case (stat.req)
						REQ_SEND:   state_d = stat.full ? S_RESULT : S_SEND_WR;
						REQ_LIST:   state_d = stat.cnt_zero ? S_RESULT : S_LIST_RD;
						REQ_REMOVE: state_d = S_SH_RD;
						default:    state_d = S_RESULT;
					endcase
				end
			end
			S_SEND_WR: state_d = S_RESULT;
			S_RESULT: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			S_LIST_RD: state_d = S_LIST_CHK;
			S_LIST_CHK: begin
				if (!stat.list_hit) begin
					state_d = S_LIST_RD;
				end else if (stat.out_free) begin
					state_d = stat.list_last ? S_IDLE : S_LIST_RD;
				end
			end
			S_SH_RD: state_d = stat.shift_more ? S_SH_WR : S_RESULT;
			S_SH_WR: state_d = S_SH_RD;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_DECODE: begin
				cmd.scan_start = (stat.req != REQ_REMOVE) && !stat.bad_task;
			end
			S_RM_READ: cmd.rd_slot = 1'b1;
			S_RM_CAP: begin
				cmd.rm_cap     = 1'b1;
				cmd.scan_start = 1'b1;
			end
			S_SCAN:    cmd.scan_run = 1'b1;
			S_SEND_WR: cmd.wr_send  = 1'b1;
			S_RESULT:  cmd.res_load = stat.out_free;
			S_LIST_RD: cmd.rd_list  = 1'b1;
			S_LIST_CHK: begin
				cmd.list_emit = stat.list_hit && stat.out_free;
				cmd.list_skip = !stat.list_hit;
			end
			S_SH_RD: begin
				cmd.rd_shift = stat.shift_more;
				cmd.fill_dec = !stat.shift_more;
			end
			S_SH_WR: cmd.wr_shift = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: rtl/mmt_dp.sv
module mmt_dp
	import mmt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic [2:0]        req_type,
	input  logic [TASK_W-1:0] dest_task,
	input  logic [TASK_W-1:0] src_task,
	input  logic [PAY_W-1:0]  payload,
	input  logic [IDX_W-1:0]  slot,
	input  cmd_t              cmd,
	output stat_t             stat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [CNT_W-1:0]  match_count,
	output logic [IDX_W-1:0]  found_slot,
	output logic [TASK_W-1:0] found_source,
	output logic [PAY_W-1:0]  found_payload,
	output logic [SEQ_W-1:0]  found_sequence,
	output logic              last
);

	logic [CNT_W-1:0]  tasks_q;
	logic [CNT_W-1:0]  fill_q;

	req_t              req_q;
	logic [TASK_W-1:0] src_q;
	logic [PAY_W-1:0]  pay_q;
	logic [IDX_W-1:0]  slot_q;
	logic              bad_task_q, slot_bad_q, full_q;
	logic [TASK_W-1:0] key_q;

	logic [CNT_W-1:0]  issue_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [CNT_W-1:0]  cnt_q;
	logic              hit_seen_q;
	logic [CNT_W-1:0]  lp_q, em_q, shp_q;

	logic [IDX_W-1:0]  hit_slot_q;
	logic [TASK_W-1:0] hit_src_q;
	logic [PAY_W-1:0]  hit_pay_q;
	logic [SEQ_W-1:0]  hit_seq_q;

	entry_t            mem_q [TABLE_DEPTH];
	entry_t            rdata_q;

	logic              scan_issue, scan_hit, rd_en, we;
	logic [IDX_W-1:0]  rd_addr, wr_addr;
	entry_t            wr_data;
	logic [CNT_W-1:0]  shp_nx;

	status_t           r_status;
	logic [CNT_W-1:0]  r_count;
	logic              r_with_hit;

	logic              out_valid_q, last_q;
	status_t           status_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  fslot_q;
	logic [TASK_W-1:0] fsrc_q;
	logic [PAY_W-1:0]  fpay_q;
	logic [SEQ_W-1:0]  fseq_q;

	assign scan_issue = issue_q < fill_q;
	assign scan_hit   = vld_s1 && (rdata_q.dest == key_q);
	assign shp_nx     = shp_q + CNT_W'(1);

	assign stat.req        = req_q;
	assign stat.bad_task   = bad_task_q;
	assign stat.slot_bad   = slot_bad_q;
	assign stat.full       = full_q;
	assign stat.cnt_zero   = (cnt_q == '0);
	assign stat.scan_done  = !scan_issue && !vld_s1;
	assign stat.shift_more = shp_nx < fill_q;
	assign stat.list_hit   = (rdata_q.dest == key_q);
	assign stat.list_last  = ((em_q + CNT_W'(1)) == cnt_q);
	assign stat.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tasks_q <= CNT_W'(1);
		end else if (cfg_we) begin
			tasks_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.wr_send) begin
			fill_q <= fill_q + CNT_W'(1);
		end else if (cmd.fill_dec) begin
			fill_q <= fill_q - CNT_W'(1);
		end
	end

	// request latch; decisions are taken against the fill level at acceptance
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q      <= req_t'(req_type);
			src_q      <= src_task;
			pay_q      <= payload;
			slot_q     <= slot;
			key_q      <= dest_task;
			bad_task_q <= ({1'b0, dest_task} >= tasks_q) ||
			              ({1'b0, dest_task} >= CNT_W'(MAX_TASKS));
			slot_bad_q <= ({1'b0, slot} >= fill_q);
			full_q     <= (fill_q == CNT_W'(TABLE_DEPTH));
		end else if (cmd.rm_cap) begin
			key_q <= rdata_q.dest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q    <= '0;
			vld_s1     <= 1'b0;
			cnt_q      <= '0;
			hit_seen_q <= 1'b0;
			lp_q       <= '0;
			em_q       <= '0;
			shp_q      <= '0;
		end else begin
			vld_s1 <= cmd.scan_run && scan_issue;
			if (cmd.scan_start) begin
				issue_q    <= '0;
				cnt_q      <= '0;
				hit_seen_q <= 1'b0;
				lp_q       <= '0;
				em_q       <= '0;
			end else begin
				if (cmd.scan_run && scan_issue) issue_q <= issue_q + CNT_W'(1);
				if (scan_hit) begin
					cnt_q      <= cnt_q + CNT_W'(1);
					hit_seen_q <= 1'b1;
				end
				if (cmd.list_emit || cmd.list_skip) lp_q <= lp_q + CNT_W'(1);
				if (cmd.list_emit) em_q <= em_q + CNT_W'(1);
			end
			if (cmd.rm_cap) begin
				shp_q <= {1'b0, slot_q};
			end else if (cmd.wr_shift) begin
				shp_q <= shp_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_run) idx_s1 <= issue_q[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.rm_cap) begin
			hit_slot_q <= slot_q;
			hit_src_q  <= rdata_q.src;
			hit_pay_q  <= rdata_q.pay;
			hit_seq_q  <= rdata_q.seq;
		end else if (cmd.wr_send) begin
			hit_slot_q <= fill_q[IDX_W-1:0];
			hit_src_q  <= src_q;
			hit_pay_q  <= pay_q;
			hit_seq_q  <= cnt_q[SEQ_W-1:0];
		end else if (scan_hit && ((req_q == REQ_FIRST && !hit_seen_q) ||
		                          req_q == REQ_LAST)) begin
			hit_slot_q <= idx_s1;
			hit_src_q  <= rdata_q.src;
			hit_pay_q  <= rdata_q.pay;
			hit_seq_q  <= rdata_q.seq;
		end
	end

	// entry table: one write and one read port, registered read data
	always_comb begin
		rd_en = (cmd.scan_run && scan_issue) || cmd.rd_slot || cmd.rd_list || cmd.rd_shift;
		if (cmd.rd_slot) begin
			rd_addr = slot_q;
		end else if (cmd.rd_list) begin
			rd_addr = lp_q[IDX_W-1:0];
		end else if (cmd.rd_shift) begin
			rd_addr = shp_nx[IDX_W-1:0];
		end else begin
			rd_addr = issue_q[IDX_W-1:0];
		end
		we = cmd.wr_send || cmd.wr_shift;
		if (cmd.wr_send) begin
			wr_addr      = fill_q[IDX_W-1:0];
			wr_data.dest = key_q;
			wr_data.src  = src_q;
			wr_data.pay  = pay_q;
			wr_data.seq  = cnt_q[SEQ_W-1:0];
		end else begin
			wr_addr = shp_q[IDX_W-1:0];
			wr_data = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem_q[rd_addr];
	end

	// single-result outcome
	always_comb begin
		r_status   = STS_OK;
		r_count    = '0;
		r_with_hit = 1'b0;
		case (req_q)
			REQ_SEND: begin
				if (bad_task_q) begin
					r_status = STS_BAD_TASK;
				end else if (full_q) begin
					r_status = STS_FULL;
					r_count  = cnt_q;
				end else begin
					r_count    = cnt_q + CNT_W'(1);
					r_with_hit = 1'b1;
				end
			end
			REQ_COUNT: begin
				if (bad_task_q) r_status = STS_BAD_TASK;
				else r_count = cnt_q;
			end
			REQ_FIRST, REQ_LAST: begin
				if (bad_task_q) begin
					r_status = STS_BAD_TASK;
				end else if (cnt_q == '0) begin
					r_status = STS_NONE;
				end else begin
					r_count    = cnt_q;
					r_with_hit = 1'b1;
				end
			end
			REQ_LIST: r_status = bad_task_q ? STS_BAD_TASK : STS_NONE;
			REQ_REMOVE: begin
				if (slot_bad_q) begin
					r_status = STS_BAD_SLOT;
				end else begin
					// count was taken before the entry left the table
					r_count    = cnt_q - CNT_W'(1);
					r_with_hit = 1'b1;
				end
			end
			default: r_status = STS_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load || cmd.list_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q <= r_status;
			count_q  <= r_count;
			last_q   <= 1'b1;
			fslot_q  <= r_with_hit ? hit_slot_q : '0;
			fsrc_q   <= r_with_hit ? hit_src_q  : '0;
			fpay_q   <= r_with_hit ? hit_pay_q  : '0;
			fseq_q   <= r_with_hit ? hit_seq_q  : '0;
		end else if (cmd.list_emit) begin
			status_q <= STS_OK;
			count_q  <= cnt_q;
			last_q   <= stat.list_last;
			fslot_q  <= lp_q[IDX_W-1:0];
			fsrc_q   <= rdata_q.src;
			fpay_q   <= rdata_q.pay;
			fseq_q   <= rdata_q.seq;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign match_count    = count_q;
	assign found_slot     = fslot_q;
	assign found_source   = fsrc_q;
	assign found_payload  = fpay_q;
	assign found_sequence = fseq_q;
	assign last           = last_q;

endmodule

FILE: rtl/mmt_checker.sv
module mmt_checker
	import mmt_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [2:0]        status,
	input logic [CNT_W-1:0]  match_count,
	input logic [IDX_W-1:0]  found_slot,
	input logic [TASK_W-1:0] found_source,
	input logic [PAY_W-1:0]  found_payload,
	input logic [SEQ_W-1:0]  found_sequence,
	input logic              last
);

	// one request at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in progress");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(match_count) && $stable(found_slot) && $stable(found_payload) &&
		$stable(last))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= STS_BAD_SLOT)
		else $error("status code out of range");

	// any failure ends its request and carries no entry
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STS_OK |-> last && found_slot == '0 &&
		found_source == '0 && found_payload == '0 && found_sequence == '0)
		else $error("error result malformed");

endmodule

bind message_mailbox_table mmt_checker u_mmt_checker (.*);

FILE: tb/tb.sv
module tb;
	import mmt_pkg::*;

	localparam int WDOG_LIMIT    = 3000;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_REQS    = 65;

	// request codes the block ignores
	localparam logic [2:0] REQ_SPARE6 = 3'd6;
	localparam logic [2:0] REQ_SPARE7 = 3'd7;

	typedef struct packed {
		logic [2:0]        req;
		logic [TASK_W-1:0] dest;
		logic [TASK_W-1:0] src;
		logic [PAY_W-1:0]  pay;
		logic [IDX_W-1:0]  slot;
	} mbox_req_t;

	typedef struct packed {
		status_t           status;
		logic [CNT_W-1:0]  cnt;
		logic [IDX_W-1:0]  slot;
		logic [TASK_W-1:0] src;
		logic [PAY_W-1:0]  pay;
		logic [SEQ_W-1:0]  seq;
		logic              last;
	} mbox_reply_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CNT_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [2:0]        req_type = '0;
	logic [TASK_W-1:0] dest_task = '0;
	logic [TASK_W-1:0] src_task = '0;
	logic [PAY_W-1:0]  payload = '0;
	logic [IDX_W-1:0]  slot = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [2:0]        status;
	logic [CNT_W-1:0]  match_count;
	logic [IDX_W-1:0]  found_slot;
	logic [TASK_W-1:0] found_source;
	logic [PAY_W-1:0]  found_payload;
	logic [SEQ_W-1:0]  found_sequence;
	logic              last;

	message_mailbox_table i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.dest_task      (dest_task),
		.src_task       (src_task),
		.payload        (payload),
		.slot           (slot),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.match_count    (match_count),
		.found_slot     (found_slot),
		.found_source   (found_source),
		.found_payload  (found_payload),
		.found_sequence (found_sequence),
		.last           (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow mailbox table
	logic [TASK_W-1:0] sh_dest [TABLE_DEPTH];
	logic [TASK_W-1:0] sh_src  [TABLE_DEPTH];
	logic [PAY_W-1:0]  sh_pay  [TABLE_DEPTH];
	logic [SEQ_W-1:0]  sh_seq  [TABLE_DEPTH];
	int sh_fill = 0;
	int lim_tasks = 1;

	mbox_req_t   req_backlog [$];
	mbox_reply_t due_replies [$];

	int n_reqs = 0, n_replies = 0, n_cfg = 0, bad_replies = 0;
	int full_hits = 0, longest_list = 0;
	int gap_cnt = 0, stall_cnt = 0, hold_cnt = 0, hold_reqs = 0, hold_done = 0;
	int quiet = 0;
	bit calm = 1'b0;
	bit fill_mode = 1'b1;
	mbox_req_t   nxt;
	mbox_reply_t got, want;

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic string reply_str(input mbox_reply_t x);
		return $sformatf("st=%0d cnt=%0d slot=%0d src=%0d pay=%h seq=%0d last=%0d",
			x.status, x.cnt, x.slot, x.src, x.pay, x.seq, x.last);
	endfunction

	function automatic int queued_for(input logic [TASK_W-1:0] d);
		int n;
		n = 0;
		for (int z = 0; z < sh_fill; z++)
			if (sh_dest[z] == d)
				n++;
		return n;
	endfunction

	function automatic mbox_reply_t entry_reply(input int z);
		mbox_reply_t x;
		x = '0;
		x.status = STS_OK;
		x.slot = IDX_W'(z);
		x.src = sh_src[z];
		x.pay = sh_pay[z];
		x.seq = sh_seq[z];
		x.last = 1'b1;
		return x;
	endfunction

	// works out the replies to one accepted request and updates the shadow table
	function automatic void mailbox_apply(input mbox_req_t r);
		mbox_reply_t rep, held;
		logic [TASK_W-1:0] d;
		int n, k;
		rep = '0;
		rep.last = 1'b1;
		if (r.req > REQ_REMOVE)
			return;
		if (r.req == REQ_REMOVE) begin
			if (r.slot >= sh_fill) begin
				rep.status = STS_BAD_SLOT;
			end else begin
				rep = entry_reply(r.slot);
				d = sh_dest[r.slot];
				for (int z = r.slot; z + 1 < sh_fill; z++) begin
					sh_dest[z] = sh_dest[z + 1];
					sh_src[z] = sh_src[z + 1];
					sh_pay[z] = sh_pay[z + 1];
					sh_seq[z] = sh_seq[z + 1];
				end
				sh_fill--;
				rep.cnt = CNT_W'(queued_for(d));
			end
			due_replies.push_back(rep);
			return;
		end
		if (r.dest >= lim_tasks) begin
			rep.status = STS_BAD_TASK;
			due_replies.push_back(rep);
			return;
		end
		n = queued_for(r.dest);
		case (r.req)
			REQ_SEND: begin
				if (sh_fill >= TABLE_DEPTH) begin
					rep.status = STS_FULL;
					rep.cnt = CNT_W'(n);
					full_hits++;
				end else begin
					sh_dest[sh_fill] = r.dest;
					sh_src[sh_fill] = r.src;
					sh_pay[sh_fill] = r.pay;
					sh_seq[sh_fill] = SEQ_W'(n);
					rep = entry_reply(sh_fill);
					rep.cnt = CNT_W'(n + 1);
					sh_fill++;
				end
			end
			REQ_COUNT: rep.cnt = CNT_W'(n);
			REQ_FIRST, REQ_LAST: begin
				k = -1;
				for (int z = 0; z < sh_fill; z++)
					if (sh_dest[z] == r.dest && (k < 0 || r.req == REQ_LAST))
						k = z;
				if (k >= 0) begin
					rep = entry_reply(k);
					rep.cnt = CNT_W'(n);
				end else begin
					rep.status = STS_NONE;
				end
			end
			default: begin
				k = 0;
				held = '0;
				for (int z = 0; z < sh_fill; z++)
					if (sh_dest[z] == r.dest) begin
						if (k > 0)
							due_replies.push_back(held);
						held = entry_reply(z);
						held.cnt = CNT_W'(n);
						held.last = 1'b0;
						k++;
					end
				if (k > 0) begin
					held.last = 1'b1;
					due_replies.push_back(held);
					if (k > longest_list)
						longest_list = k;
					return;
				end
				rep.status = STS_NONE;
			end
		endcase
		due_replies.push_back(rep);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			req_type <= '0;
			dest_task <= '0;
			src_task <= '0;
			payload <= '0;
			slot <= '0;
			gap_cnt = 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				mailbox_apply({req_type, dest_task, src_task, payload, slot});
				n_reqs++;
			end
			if (gap_cnt > 0) begin
				gap_cnt--;
				in_valid <= 1'b0;
			end else if (req_backlog.size() > 0) begin
				nxt = req_backlog.pop_front();
				in_valid <= 1'b1;
				req_type <= nxt.req;
				dest_task <= nxt.dest;
				src_task <= nxt.src;
				payload <= nxt.pay;
				slot <= nxt.slot;
				gap_cnt = calm ? 0 : idle_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_cnt = 0;
			hold_cnt = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {status_t'(status), match_count, found_slot, found_source,
					found_payload, found_sequence, last};
				n_replies++;
				if (due_replies.size() == 0) begin
					bad_replies++;
					if (bad_replies <= 10)
						$display("%0t: result with nothing expected: %s", $realtime,
							reply_str(got));
				end else begin
					want = due_replies.pop_front();
					if (got !== want) begin
						bad_replies++;
						if (bad_replies <= 10)
							$display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
								reply_str(want), reply_str(got));
					end
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else if (hold_done != hold_reqs) begin
				hold_done = hold_reqs;
				hold_cnt = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
				out_ready <= 1'b0;
			end else begin
				stall_cnt = (!calm && $urandom_range(0, 3) == 0) ? idle_len() : 0;
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= WDOG_LIMIT) begin
					$display("watchdog: no transfer for %0d cycles, %0d results pending",
						quiet, due_replies.size());
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	task automatic queue_req(input logic [2:0] rq, input int d, input int s,
		input logic [PAY_W-1:0] p, input int sl);
		req_backlog.push_back({rq, TASK_W'(d), TASK_W'(s), p, IDX_W'(sl)});
	endtask

	// wait until the table has gone quiet
	task automatic settle();
		@(negedge clk);
		while (req_backlog.size() > 0 || in_valid || due_replies.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_tasks(input int v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= CNT_W'(v);
		lim_tasks = v;
		n_cfg++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic mbox_req_t random_req();
		mbox_req_t r;
		int pick, send_w, rm_w;
		send_w = fill_mode ? 50 : 15;
		rm_w = fill_mode ? 10 : 40;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 3)
			r.req = $urandom_range(0, 1) ? REQ_SPARE7 : REQ_SPARE6;
		else if (pick < send_w)
			r.req = REQ_SEND;
		else if (pick < send_w + rm_w)
			r.req = REQ_REMOVE;
		else
			r.req = 3'($urandom_range(REQ_COUNT, REQ_LIST));
		r.dest = ($urandom_range(0, 9) == 0) ? TASK_W'($urandom_range(0, 15))
			: TASK_W'($urandom_range(0, lim_tasks - 1));
		r.src = TASK_W'($urandom_range(0, 15));
		r.pay = $urandom;
		r.slot = (sh_fill > 0 && $urandom_range(0, 5) != 0)
			? IDX_W'($urandom_range(0, sh_fill - 1)) : IDX_W'($urandom_range(0, 15));
		return r;
	endfunction

	initial begin : main
		int limits [6];
		limits = '{1, 16, 9, 2, 0, 5};
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset limit of one task: empty table, rejected tasks and one accepted send
		queue_req(REQ_FIRST, 0, 0, 32'h0, 0);
		queue_req(REQ_LIST, 0, 0, 32'h0, 0);
		queue_req(REQ_REMOVE, 0, 0, 32'h0, 0);
		queue_req(REQ_SEND, 1, 2, 32'h1234_5678, 0);
		queue_req(REQ_COUNT, 15, 0, 32'h0, 0);
		queue_req(REQ_SEND, 0, 15, 32'hffff_ffff, 15);
		settle();

		set_tasks(16);
		queue_req(REQ_SEND, 15, 0, 32'h0, 0);
		queue_req(REQ_SEND, 15, 5, 32'ha5a5_a5a5, 0);
		queue_req(REQ_SEND, 0, 7, 32'h5a5a_5a5a, 0);
		queue_req(REQ_SPARE6, $urandom_range(0, 15), 3, $urandom, $urandom_range(0, 15));
		queue_req(REQ_SPARE7, $urandom_range(0, 15), 12, $urandom, $urandom_range(0, 15));
		queue_req(REQ_COUNT, 15, 0, 32'h0, 0);
		queue_req(REQ_FIRST, 15, 0, 32'h0, 0);
		queue_req(REQ_LAST, 15, 0, 32'h0, 0);
		queue_req(REQ_LIST, 15, 0, 32'h0, 0);
		queue_req(REQ_LIST, 0, 0, 32'h0, 0);
		queue_req(REQ_REMOVE, 3, 0, 32'h0, 15);
		queue_req(REQ_REMOVE, 0, 0, 32'h0, 0);
		queue_req(REQ_LAST, 0, 0, 32'h0, 0);
		// sequence numbers carry on from the count, not renumbered
		queue_req(REQ_SEND, 15, 9, 32'h8000_0001, 0);
		queue_req(REQ_REMOVE, 0, 0, 32'h0, 3);
		queue_req(REQ_LIST, 9, 0, 32'h0, 0);

		for (int ph = 0; ph < 6; ph++) begin
			settle();
			set_tasks(limits[ph] == 0 ? $urandom_range(1, 16) : limits[ph]);
			fill_mode = 1'b1;
			for (int i = 0; i < PHASE_REQS; i++) begin
				while (req_backlog.size() >= 2)
					@(negedge clk);
				if (i % 20 == 0)
					calm = ($urandom_range(0, 3) == 0);
				if (i == 10 && (ph == 0 || ph == 3))
					hold_reqs++;
				if (i == 40)
					settle();
				if (sh_fill >= TABLE_DEPTH && $urandom_range(0, 2) == 0)
					fill_mode = 1'b0;
				else if (sh_fill <= 1)
					fill_mode = 1'b1;
				req_backlog.push_back(random_req());
			end
		end
		settle();

		$display("Covered %0d requests and %0d results across %0d task-limit settings;",
			n_reqs, n_replies, n_cfg);
		$display("%0d sends into a full table, longest list %0d entries, %0d bad results.",
			full_hits, longest_list, bad_replies);
		if (bad_replies == 0 && due_replies.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
